[sv/ihp_pkg.sv]
`default_nettype none
package ihp_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned HandleW = 11;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 11;

  // command field codes
  localparam logic [CmdW-1:0] CMD_INSERT     = 3'd0;
  localparam logic [CmdW-1:0] CMD_PEEK       = 3'd1;
  localparam logic [CmdW-1:0] CMD_DEL_MIN    = 3'd2;
  localparam logic [CmdW-1:0] CMD_DEL_HANDLE = 3'd3;
  localparam logic [CmdW-1:0] CMD_CHANGE     = 3'd4;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_PEEK,
    OP_DEL_MIN,
    OP_DEL_HANDLE,
    OP_CHANGE
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK,
    ST_EMPTY,
    ST_FULL,
    ST_BAD_HANDLE
  } status_e;

  typedef struct packed {
    op_e                      op;
    logic [HandleW-1:0]       handle;
    logic signed [ValueW-1:0] value;
  } req_t;

endpackage
`default_nettype wire

[sv/ihp_in_if.sv]
`default_nettype none
interface ihp_in_if;
  import ihp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CmdW-1:0]          command;
  logic [HandleW-1:0]       handle;
  logic signed [ValueW-1:0] value;

  modport source (output valid, command, handle, value, input ready);
  modport sink   (input valid, command, handle, value, output ready);
endinterface
`default_nettype wire

[sv/ihp_out_if.sv]
`default_nettype none
interface ihp_out_if;
  import ihp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [StatusW-1:0]       status;
  logic signed [ValueW-1:0] min_value;
  logic [HandleW-1:0]       new_handle;
  logic [CountW-1:0]        entry_count;

  modport source (output valid, status, min_value, new_handle, entry_count, input ready);
  modport sink   (input valid, status, min_value, new_handle, entry_count, output ready);
endinterface
`default_nettype wire

[sv/ihp_front.sv]
`default_nettype none
module ihp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  ihp_in_if.sink             in_i,
  output logic               req_valid_o,
  output ihp_pkg::req_t      req_o,
  input  wire logic          req_ready_i
);
  import ihp_pkg::*;

  req_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  op_e        op;
  logic       push, pop;

  // decode command code; unused codes behave as peek
  always_comb begin
    case (in_i.command)
      CMD_INSERT:     op = OP_INSERT;
      CMD_PEEK:       op = OP_PEEK;
      CMD_DEL_MIN:    op = OP_DEL_MIN;
      CMD_DEL_HANDLE: op = OP_DEL_HANDLE;
      CMD_CHANGE:     op = OP_CHANGE;
      default:        op = OP_PEEK;
    endcase
  end

  assign in_i.ready  = (fill_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign req_valid_o = (fill_q != 2'd0);
  assign pop         = req_valid_o && req_ready_i;
  assign req_o       = buf_q[rd_ptr_q];

  // two-entry item queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= '{op: op, handle: in_i.handle, value: in_i.value};
  end
endmodule
`default_nettype wire

[sv/ihp_engine.sv]
`default_nettype none
module ihp_engine #(
  parameter int unsigned HEAP_SIZE    = 1024,
  parameter int unsigned HANDLE_COUNT = 1024,
  parameter int unsigned SlotW        = $clog2(HEAP_SIZE + 1),
  parameter int unsigned HdlW         = $clog2(HANDLE_COUNT + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  input  wire ihp_pkg::req_t   req_i,
  output logic                 req_ready_o,
  ihp_out_if.source            out_o,
  output logic [SlotW-1:0]     count_o,
  output logic [HdlW-1:0]      issued_o
);
  import ihp_pkg::*;

  localparam int unsigned CmpW = (HdlW > HandleW) ? HdlW : HandleW;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_LAST, S_DRD, S_DCMP, S_URD, S_UCMP, S_FIN
  } state_e;

  state_e                   state_q;
  op_e                      op_q;
  logic [HandleW-1:0]       h_q;
  logic signed [ValueW-1:0] v_q;
  logic [SlotW-1:0]         s_q;
  logic signed [ValueW-1:0] x_q;
  logic [HdlW-1:0]          hx_q;
  logic                     moved_q;
  logic [SlotW-1:0]         count_q;
  logic [HdlW-1:0]          issued_q;
  logic signed [ValueW-1:0] min_q;
  status_e                  status_q;
  logic [HdlW-1:0]          given_q;
  logic                     ov_q;
  status_e                  o_status_q;
  logic signed [ValueW-1:0] o_min_q;
  logic [HandleW-1:0]       o_handle_q;
  logic [CountW-1:0]        o_count_q;

  // storage: slots indexed from 1, handles indexed from 1
  logic signed [ValueW-1:0] val_mem [2**SlotW];
  logic [HdlW-1:0]          hos_mem [2**SlotW];
  logic [SlotW-1:0]         soh_mem [2**HdlW];
  logic                     live_mem [2**HdlW];

  logic signed [ValueW-1:0] val_a_q, val_b_q;
  logic [HdlW-1:0]          hos_a_q, hos_b_q;
  logic [SlotW-1:0]         soh_q;
  logic                     live_q;

  logic [SlotW-1:0]         rd_a, rd_b;
  logic [HdlW-1:0]          rd_h;
  logic [SlotW:0]           child_l, child_r;
  logic                     l_ok, r_ok, take_l, take_r, down_move, up_move;
  logic signed [ValueW-1:0] best_v, c_val;
  logic [HdlW-1:0]          c_h, del_h;
  logic [SlotW-1:0]         c_slot;
  logic                     full, bad_range;

  logic                     hw_en;
  logic [SlotW-1:0]         hw_slot;
  logic signed [ValueW-1:0] hw_val;
  logic [HdlW-1:0]          hw_h;
  logic                     lw_en, lw_val;
  logic [HdlW-1:0]          lw_addr;

  assign child_l = {s_q, 1'b0};
  assign child_r = child_l + 1'b1;
  assign rd_h    = HdlW'(req_i.handle);

  // read addresses
  always_comb begin
    case (state_q)
      S_DRD: begin
        rd_a = SlotW'(child_l);
        rd_b = SlotW'(child_r);
      end
      S_URD: begin
        rd_a = s_q >> 1;
        rd_b = SlotW'(1);
      end
      default: begin
        rd_a = count_q;
        rd_b = SlotW'(1);
      end
    endcase
  end

  // child selection and parent compare
  always_comb begin
    l_ok      = child_l <= {1'b0, count_q};
    r_ok      = child_r <= {1'b0, count_q};
    take_l    = l_ok && (val_a_q < x_q);
    best_v    = take_l ? val_a_q : x_q;
    take_r    = r_ok && (val_b_q < best_v);
    down_move = take_l || take_r;
    c_val     = take_r ? val_b_q : val_a_q;
    c_h       = take_r ? hos_b_q : hos_a_q;
    c_slot    = take_r ? SlotW'(child_r) : SlotW'(child_l);
    up_move   = x_q < val_a_q;
    del_h     = (op_q == OP_DEL_MIN) ? hos_b_q : HdlW'(h_q);
    full      = (count_q == SlotW'(HEAP_SIZE)) || (issued_q == HdlW'(HANDLE_COUNT));
    bad_range = (req_i.handle == '0) || (CmpW'(req_i.handle) > CmpW'(issued_q));
  end

  // memory write ports
  always_comb begin
    hw_en   = 1'b0;
    hw_slot = s_q;
    hw_val  = x_q;
    hw_h    = hx_q;
    lw_en   = 1'b0;
    lw_addr = del_h;
    lw_val  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i && req_i.op == OP_INSERT && !full) begin
          lw_en   = 1'b1;
          lw_addr = issued_q + 1'b1;
          lw_val  = 1'b1;
        end
      end
      S_LAST: lw_en = 1'b1;
      S_DCMP: begin
        if (down_move) begin
          hw_en  = 1'b1;
          hw_val = c_val;
          hw_h   = c_h;
        end else if (moved_q) begin
          hw_en = 1'b1;
        end
      end
      S_URD: hw_en = (s_q == SlotW'(1));
      S_UCMP: begin
        hw_en = 1'b1;
        if (up_move) begin
          hw_val = val_a_q;
          hw_h   = hos_a_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hw_en) begin
      val_mem[hw_slot] <= hw_val;
      hos_mem[hw_slot] <= hw_h;
      soh_mem[hw_h]    <= hw_slot;
    end
    if (lw_en) live_mem[lw_addr] <= lw_val;
    val_a_q <= val_mem[rd_a];
    val_b_q <= val_mem[rd_b];
    hos_a_q <= hos_mem[rd_a];
    hos_b_q <= hos_mem[rd_b];
    soh_q   <= soh_mem[rd_h];
    live_q  <= live_mem[rd_h];
  end

  // command sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      issued_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (ov_q && out_o.ready && state_q != S_FIN) ov_q <= 1'b0;
      if (hw_en && hw_slot == SlotW'(1)) min_q <= hw_val;
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            op_q     <= req_i.op;
            h_q      <= req_i.handle;
            v_q      <= req_i.value;
            given_q  <= '0;
            status_q <= ST_OK;
            case (req_i.op)
              OP_INSERT: begin
                if (full) begin
                  status_q <= ST_FULL;
                  state_q  <= S_FIN;
                end else begin
                  issued_q <= issued_q + 1'b1;
                  count_q  <= count_q + 1'b1;
                  given_q  <= issued_q + 1'b1;
                  hx_q     <= issued_q + 1'b1;
                  s_q      <= count_q + 1'b1;
                  x_q      <= req_i.value;
                  moved_q  <= 1'b0;
                  state_q  <= S_URD;
                end
              end
              OP_DEL_MIN: begin
                if (count_q == '0) begin
                  status_q <= ST_EMPTY;
                  state_q  <= S_FIN;
                end else begin
                  s_q     <= SlotW'(1);
                  state_q <= S_LAST;
                end
              end
              OP_DEL_HANDLE, OP_CHANGE: begin
                if (bad_range) begin
                  status_q <= ST_BAD_HANDLE;
                  state_q  <= S_FIN;
                end else begin
                  state_q <= S_CHECK;
                end
              end
              default: begin
                if (count_q == '0) status_q <= ST_EMPTY;
                state_q <= S_FIN;
              end
            endcase
          end
        end
        S_CHECK: begin
          if (!live_q) begin
            status_q <= ST_BAD_HANDLE;
            state_q  <= S_FIN;
          end else begin
            s_q <= soh_q;
            if (op_q == OP_CHANGE) begin
              x_q     <= v_q;
              hx_q    <= HdlW'(h_q);
              moved_q <= 1'b0;
              state_q <= S_DRD;
            end else begin
              state_q <= S_LAST;
            end
          end
        end
        S_LAST: begin
          // last entry fills the vacated slot
          count_q <= count_q - 1'b1;
          if (s_q <= count_q - 1'b1) begin
            x_q     <= val_a_q;
            hx_q    <= hos_a_q;
            moved_q <= 1'b0;
            state_q <= S_DRD;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_DRD: state_q <= S_DCMP;
        S_DCMP: begin
          if (down_move) begin
            s_q     <= c_slot;
            moved_q <= 1'b1;
            state_q <= S_DRD;
          end else if (moved_q) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_URD;
          end
        end
        S_URD: state_q <= (s_q == SlotW'(1)) ? S_FIN : S_UCMP;
        S_UCMP: begin
          if (up_move) begin
            s_q     <= s_q >> 1;
            state_q <= S_URD;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!ov_q || out_o.ready) begin
            ov_q       <= 1'b1;
            o_status_q <= status_q;
            o_min_q    <= (count_q != '0) ? min_q : '0;
            o_handle_q <= HandleW'(given_q);
            o_count_q  <= CountW'(count_q);
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_ready_o       = (state_q == S_IDLE);
  assign out_o.valid       = ov_q;
  assign out_o.status      = o_status_q;
  assign out_o.min_value   = o_min_q;
  assign out_o.new_handle  = o_handle_q;
  assign out_o.entry_count = o_count_q;
  assign count_o           = count_q;
  assign issued_o          = issued_q;
endmodule
`default_nettype wire

[sv/indexed_min_heap.sv]
// Indexed binary min-heap of signed 32-bit values.
// Input channel in_i carries command, handle and value; output channel out_o
// returns one item per command: status, min_value, new_handle, entry_count.
// Inserted values get handles 1, 2, 3, ... in order; handles are not reused.
// A two-entry queue in front takes items while the heap sequencer works, so
// the sender sees ready until two items wait.
// From input accept to result valid, peek and refused commands go straight to
// the final step, after a live-bit check for a dead handle; insert climbs from
// the new last slot; delete-min moves the last entry to the root and sifts it
// down; delete and change by handle first look up the handle's slot, and the
// entry then sifts down or climbs.
// Throughput is one command at a time, set by the sift loop over the value
// and slot/handle memories (one read and one write per port per cycle).
// The result sits in an output register; a stalled receiver holds it and the
// sequencer waits in its final step until the register frees.
// Reset empties the heap and the handle counter; no clearing pass is needed,
// as a handle is looked up only after it was issued.
`default_nettype none
module indexed_min_heap #(
  parameter int unsigned HEAP_SIZE    = 1024,
  parameter int unsigned HANDLE_COUNT = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ihp_in_if.sink    in_i,
  ihp_out_if.source out_o
);
  import ihp_pkg::*;

  localparam int unsigned SlotW = $clog2(HEAP_SIZE + 1);
  localparam int unsigned HdlW  = $clog2(HANDLE_COUNT + 1);

  logic             req_valid, req_ready;
  req_t             req;
  logic [SlotW-1:0] count;
  logic [HdlW-1:0]  issued;

  ihp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  ihp_engine #(
    .HEAP_SIZE    (HEAP_SIZE),
    .HANDLE_COUNT (HANDLE_COUNT),
    .SlotW        (SlotW),
    .HdlW         (HdlW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_ready_o (req_ready),
    .out_o       (out_o),
    .count_o     (count),
    .issued_o    (issued)
  );

  // every heap entry owns a distinct issued handle
  a_count_le_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count) <= 32'(issued)) else $error("entry count above issued handles");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count) <= HEAP_SIZE) else $error("entry count above heap size");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == ST_EMPTY |-> out_o.entry_count == '0)
    else $error("empty status with entries present");

  a_handle_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.new_handle != '0 |-> out_o.status == ST_OK &&
    out_o.entry_count != '0) else $error("handle issued on a failed command");
endmodule
`default_nettype wire

[verif/heap_checker.sv]
module heap_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ihp_in_if         in_i,
  ihp_out_if        out_o,
  output int        fail_count_o,
  output int        pending_o,
  output int        results_seen_o
);
  import ihp_pkg::*;

  localparam int unsigned HeapCap   = 1024;
  localparam int unsigned HandleCap = 1024;

  typedef struct {
    status_e                  status;
    logic signed [ValueW-1:0] min_value;
    logic [HandleW-1:0]       new_handle;
    logic [CountW-1:0]        entry_count;
  } heap_result_t;

  // model of the heap contents
  logic signed [ValueW-1:0] slot_val   [HeapCap+1];
  int unsigned              slot_owner [HeapCap+1];
  int unsigned              owner_slot [HandleCap+1];
  bit                       owner_live [HandleCap+1];
  int unsigned              fill;
  int unsigned              issued;

  heap_result_t expected_q[$];

  function automatic void swap_entries(int unsigned a, int unsigned b);
    int unsigned ha, hb;
    logic signed [ValueW-1:0] t;
    ha = slot_owner[a];
    hb = slot_owner[b];
    owner_slot[ha] = b;
    owner_slot[hb] = a;
    slot_owner[a]  = hb;
    slot_owner[b]  = ha;
    t = slot_val[a];
    slot_val[a] = slot_val[b];
    slot_val[b] = t;
  endfunction

  function automatic void bubble_up(int unsigned s);
    while (s > 1 && slot_val[s] < slot_val[s/2]) begin
      swap_entries(s, s/2);
      s = s / 2;
    end
  endfunction

  function automatic void bubble_down(int unsigned s);
    int unsigned best;
    forever begin
      best = s;
      if (2*s <= fill && slot_val[2*s] < slot_val[best]) best = 2*s;
      if (2*s+1 <= fill && slot_val[2*s+1] < slot_val[best]) best = 2*s+1;
      if (best == s) return;
      swap_entries(s, best);
      s = best;
    end
  endfunction

  function automatic void drop_slot(int unsigned s);
    owner_live[slot_owner[s]] = 0;
    swap_entries(s, fill);
    fill--;
    if (s <= fill) begin
      bubble_down(s);
      bubble_up(s);
    end
  endfunction

  function automatic bit handle_alive(int unsigned h);
    return h != 0 && h <= issued && h <= HandleCap && owner_live[h];
  endfunction

  // apply one command, return the expected response
  function automatic heap_result_t apply_command(logic [CmdW-1:0] cmd,
      int unsigned h, logic signed [ValueW-1:0] v);
    heap_result_t r;
    int unsigned s;
    r.status = ST_OK;
    r.new_handle = '0;
    case (cmd)
      CMD_INSERT: begin
        if (fill >= HeapCap || issued >= HandleCap) r.status = ST_FULL;
        else begin
          issued++;
          fill++;
          owner_slot[issued] = fill;
          slot_owner[fill]   = issued;
          slot_val[fill]     = v;
          owner_live[issued] = 1;
          r.new_handle = HandleW'(issued);
          bubble_up(fill);
        end
      end
      CMD_DEL_MIN: begin
        if (fill == 0) r.status = ST_EMPTY;
        else drop_slot(1);
      end
      CMD_DEL_HANDLE: begin
        if (!handle_alive(h)) r.status = ST_BAD_HANDLE;
        else drop_slot(owner_slot[h]);
      end
      CMD_CHANGE: begin
        if (!handle_alive(h)) r.status = ST_BAD_HANDLE;
        else begin
          s = owner_slot[h];
          slot_val[s] = v;
          bubble_down(s);
          bubble_up(s);
        end
      end
      default: if (fill == 0) r.status = ST_EMPTY;
    endcase
    r.min_value   = fill > 0 ? slot_val[1] : '0;
    r.entry_count = CountW'(fill);
    return r;
  endfunction

  assign pending_o = expected_q.size();

  // predict on accepted commands, compare on accepted responses
  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t e;
    int errs;
    if (!rst_ni) begin
      fill = 0;
      issued = 0;
      for (int i = 0; i <= HandleCap; i++) owner_live[i] = 0;
      fail_count_o <= 0;
      results_seen_o <= 0;
      expected_q.delete();
    end else begin
      errs = 0;
      if (in_i.valid && in_i.ready)
        expected_q.push_back(apply_command(in_i.command, in_i.handle, in_i.value));
      if (out_o.valid && out_o.ready) begin
        results_seen_o <= results_seen_o + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected response item");
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (out_o.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_o.status);
            errs++;
          end
          if (out_o.min_value !== e.min_value) begin
            $error("min_value: expected %0d, got %0d", e.min_value, out_o.min_value);
            errs++;
          end
          if (out_o.new_handle !== e.new_handle) begin
            $error("new_handle: expected %0d, got %0d", e.new_handle, out_o.new_handle);
            errs++;
          end
          if (out_o.entry_count !== e.entry_count) begin
            $error("entry_count: expected %0d, got %0d", e.entry_count,
                   out_o.entry_count);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

[verif/tb.sv]
module tb;
  import ihp_pkg::*;

  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   fail_count, pending, results_seen;
  bit   no_idle = 0;
  int   sent = 0;
  int   inserted = 0;

  ihp_in_if  cmd_ch ();
  ihp_out_if rsp_ch ();

  indexed_min_heap u_dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(cmd_ch), .out_o(rsp_ch));

  heap_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(cmd_ch), .out_o(rsp_ch),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  always #5 clk_i = ~clk_i;

  // timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // response side stalls at random
  initial rsp_ch.ready = 1'b0;
  always @(posedge clk_i)
    rsp_ch.ready <= no_idle || ($urandom_range(99) >= 17);

  initial begin
    cmd_ch.valid   = 1'b0;
    cmd_ch.command = CMD_PEEK;
    cmd_ch.handle  = '0;
    cmd_ch.value   = '0;
  end

  // drive one command and wait for its acceptance
  task automatic send_cmd(logic [CmdW-1:0] c, logic [HandleW-1:0] h,
                          logic signed [ValueW-1:0] v);
    while (!no_idle && $urandom_range(99) < 17) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= c;
    cmd_ch.handle  <= h;
    cmd_ch.value   <= v;
    do @(posedge clk_i); while (!cmd_ch.ready);
    sent++;
    if (c == CMD_INSERT) inserted++;
  endtask

  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(40))) - 20;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic [HandleW-1:0] pick_handle();
    if ($urandom_range(9) == 0) return HandleW'($urandom());
    if (inserted == 0) return '0;
    return HandleW'($urandom_range(inserted, inserted > 40 ? inserted - 40 : 1));
  endfunction

  initial begin
    logic [CmdW-1:0] c;
    int r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty heap, extremes, bad handles, unused codes
    send_cmd(CMD_PEEK, '0, '0);
    send_cmd(CMD_DEL_MIN, '0, '0);
    send_cmd(CMD_DEL_HANDLE, 11'd0, '0);
    send_cmd(CMD_CHANGE, 11'd1, '0);
    send_cmd(CMD_INSERT, '0, 32'sh7fff_ffff);
    send_cmd(CMD_INSERT, '0, 32'sh8000_0000);
    send_cmd(CMD_INSERT, '0, 32'sd0);
    send_cmd(CMD_INSERT, '0, -32'sd1);
    send_cmd(CMD_INSERT, '0, 32'sd0);
    send_cmd(3'd5, '0, '0);
    send_cmd(3'd6, 11'h7ff, 32'shffff_ffff);
    send_cmd(3'd7, '0, '0);
    send_cmd(CMD_CHANGE, 11'd1, 32'sh8000_0000);
    send_cmd(CMD_CHANGE, 11'd2, 32'sh7fff_ffff);
    send_cmd(CMD_DEL_HANDLE, 11'd3, '0);
    send_cmd(CMD_DEL_HANDLE, 11'd3, '0);
    send_cmd(CMD_CHANGE, 11'd3, '0);
    send_cmd(CMD_DEL_HANDLE, 11'h7ff, '0);
    send_cmd(CMD_CHANGE, 11'd6, '0);
    send_cmd(CMD_DEL_MIN, '0, '0);
    send_cmd(CMD_DEL_MIN, '0, '0);
    send_cmd(CMD_DEL_MIN, '0, '0);
    send_cmd(CMD_DEL_MIN, '0, '0);
    send_cmd(CMD_DEL_MIN, '0, '0);

    // hold off until the heap has answered everything
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    // random mix, weighted toward inserts so the heap grows deep
    for (int i = 0; i < 850; i++) begin
      no_idle = (i >= 300 && i < 400);
      r = $urandom_range(99);
      if (r < 45)      c = CMD_INSERT;
      else if (r < 55) c = CMD_PEEK;
      else if (r < 68) c = CMD_DEL_MIN;
      else if (r < 82) c = CMD_DEL_HANDLE;
      else if (r < 97) c = CMD_CHANGE;
      else             c = CmdW'($urandom_range(7, 5));
      send_cmd(c, pick_handle(), pick_value());
    end
    no_idle = 0;

    for (int i = 0; i < 30; i++) send_cmd(CMD_DEL_MIN, '0, '0);

    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("tb: %0d commands sent (%0d inserts), %0d responses checked", sent,
             inserted, results_seen);
    $display("tb: covered empty, bad-handle, change, delete and unused-code paths");
    if (fail_count == 0 && pending == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end
endmodule

[files.f]
sv/ihp_pkg.sv
sv/ihp_in_if.sv
sv/ihp_out_if.sv
sv/ihp_front.sv
sv/ihp_engine.sv
sv/indexed_min_heap.sv
verif/heap_checker.sv
verif/tb.sv
